### src/lbvs_pkg.sv
`default_nettype none
// ============================================================================
// lbvs_pkg
// Shared constants, types and fixed-point helpers for the skinning pipeline.
// ============================================================================
package lbvs_pkg;

    localparam int MAX_BONES   = 128;
    localparam int FRAC_BITS   = 16;
    localparam int WEIGHT_FRAC = 15;
    localparam int NUM_INFL    = 4;
    localparam int MAT_ELEMS   = 16;
    localparam int TABLE_DEPTH = MAX_BONES * MAT_ELEMS;
    localparam int BONE_AW     = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int QUOT_W      = 32 + FRAC_BITS;

    localparam logic [1:0] CMD_SKIN      = 2'd0;
    localparam logic [1:0] CMD_LOAD_POSE = 2'd1;
    localparam logic [1:0] CMD_LOAD_INV  = 2'd2;

    typedef logic signed [31:0] fix_t;
    typedef logic [MAT_ELEMS-1:0][31:0] mat_t;
    typedef logic [NUM_INFL-1:0][15:0] weights_t;
    typedef logic [2:0][31:0] vec3_t;

    typedef struct packed {
        logic               pose_we;
        logic               inv_we;
        logic [BONE_AW-1:0] row;
        logic [3:0]         elem;
        logic [31:0]        value;
    } tbl_wr_t;

    typedef struct packed {
        weights_t            weights;
        logic [NUM_INFL-1:0] bone_ok;
        vec3_t               pos;
        vec3_t               norm;
    } side_t;

    typedef struct packed {
        logic [2:0][QUOT_W-1:0] num;
        logic [31:0]            den;
        logic [2:0]             neg;
        logic                   fault;
        vec3_t                  norm;
    } div_in_t;

    // Clamp to the signed 32-bit range
    function automatic fix_t sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            sat32 = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            sat32 = 32'sh80000000;
        else
            sat32 = fix_t'(x);
    endfunction

    // Shift right by s, round to nearest, ties toward +infinity
    function automatic logic signed [63:0] round_shr(input logic signed [63:0] p,
                                                     input int s);
        round_shr = (p + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

endpackage
`default_nettype wire

### src/linear_blend_vertex_skinning.sv
`default_nettype none
// ============================================================================
// linear_blend_vertex_skinning
// Four-bone linear blend skinning of position and normal, Q16.16.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one request per cycle
//   unless stalled: a skin request with bone indices, weights, position
//   and normal, or a load request that writes one element of the pose or
//   inverse-bind table. Load requests write the tables at acceptance and
//   produce no result; a skin request accepted in the very next cycle
//   already sees the write. Output channel (out_valid / out_stall)
//   returns one result per skin request: transformed position divided by
//   w, transformed normal and the divide_fault flag.
//   Throughput: one request per cycle while no result is stalled. The path
//   has 57 register stages: table read, 7 of matrix math, a 48-stage
//   divider (one quotient bit per stage), output.
//   Tables are replicated per influence so four bones are read together.
//   Reset clears every valid bit; the tables keep no reset value and must be
//   loaded before the bones they hold are used.
//   When the receiver stalls a pending result, the whole pipeline holds
//   and in_stall rises in the same cycle; nothing is dropped or repeated.
// ============================================================================
module linear_blend_vertex_skinning import lbvs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         command,
    input  wire logic [27:0]        joints_packed,
    input  wire logic [31:0]        weights_low_pair,
    input  wire logic [31:0]        weights_high_pair,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [31:0] norm_x,
    input  wire logic signed [31:0] norm_y,
    input  wire logic signed [31:0] norm_z,
    input  wire logic [10:0]        load_slot,
    input  wire logic signed [31:0] load_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      out_pos_x,
    output logic signed [31:0]      out_pos_y,
    output logic signed [31:0]      out_pos_z,
    output logic signed [31:0]      out_norm_x,
    output logic signed [31:0]      out_norm_y,
    output logic signed [31:0]      out_norm_z,
    output logic                    divide_fault
);

    logic                             adv;
    logic                             accept;
    logic                             slot_ok;
    tbl_wr_t                          tbl_wr;
    logic [NUM_INFL-1:0][BONE_AW-1:0] rd_addr;
    mat_t [NUM_INFL-1:0]              pose_rows;
    mat_t [NUM_INFL-1:0]              inv_rows;
    side_t                            side_next;
    side_t                            side_reg;
    logic                             s1_valid_reg;
    logic                             skin_valid;
    mat_t                             skin;
    vec3_t                            skin_pos;
    vec3_t                            skin_norm;
    logic                             div_valid;
    div_in_t                          div_in;
    logic                             res_valid;
    vec3_t                            res_quot;
    logic                             res_fault;
    vec3_t                            res_norm;
    logic                             out_valid_reg;
    vec3_t                            out_pos_reg;
    vec3_t                            out_norm_reg;
    logic                             out_fault_reg;

    // Advance everything unless a held result is being stalled
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    assign slot_ok        = int'(load_slot) < TABLE_DEPTH;
    assign tbl_wr.pose_we = accept && (command == CMD_LOAD_POSE) && slot_ok;
    assign tbl_wr.inv_we  = accept && (command == CMD_LOAD_INV) && slot_ok;
    assign tbl_wr.row     = BONE_AW'(load_slot[10:4]);
    assign tbl_wr.elem    = load_slot[3:0];
    assign tbl_wr.value   = load_value;

    always_comb
    begin
        for (int k = 0; k < NUM_INFL; k++)
        begin
            rd_addr[k]           = BONE_AW'(joints_packed[7*k +: 7]);
            side_next.bone_ok[k] = int'(joints_packed[7*k +: 7]) < MAX_BONES;
        end
        side_next.weights = {weights_high_pair, weights_low_pair};
        side_next.pos     = {pos_z, pos_y, pos_x};
        side_next.norm    = {norm_z, norm_y, norm_x};
    end

    lbvs_tables u_tables
    (
        .clk       (clk),
        .adv       (adv),
        .wr        (tbl_wr),
        .rd_addr   (rd_addr),
        .pose_rows (pose_rows),
        .inv_rows  (inv_rows)
    );

    // Hold side data alongside the registered table reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= accept && (command == CMD_SKIN);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            side_reg <= side_next;
    end

    lbvs_blend u_blend
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (s1_valid_reg),
        .side_in    (side_reg),
        .pose_rows  (pose_rows),
        .inv_rows   (inv_rows),
        .skin_valid (skin_valid),
        .skin       (skin),
        .pos        (skin_pos),
        .norm       (skin_norm)
    );

    lbvs_xform u_xform
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .skin_valid (skin_valid),
        .skin       (skin),
        .pos        (skin_pos),
        .norm       (skin_norm),
        .div_valid  (div_valid),
        .div_in     (div_in)
    );

    lbvs_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (div_valid),
        .din       (div_in),
        .res_valid (res_valid),
        .quot      (res_quot),
        .fault     (res_fault),
        .norm      (res_norm)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pos_reg   <= res_quot;
            out_norm_reg  <= res_norm;
            out_fault_reg <= res_fault;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_pos_x    = out_pos_reg[0];
    assign out_pos_y    = out_pos_reg[1];
    assign out_pos_z    = out_pos_reg[2];
    assign out_norm_x   = out_norm_reg[0];
    assign out_norm_y   = out_norm_reg[1];
    assign out_norm_z   = out_norm_reg[2];
    assign divide_fault = out_fault_reg;

`ifndef NO_ASSERTIONS
    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while a result is stalled");

    a_empty_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output register");

    a_fault_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && divide_fault) |->
        (out_pos_x == 0 && out_pos_y == 0 && out_pos_z == 0))
        else $error("nonzero position on divide fault");
`endif

endmodule
`default_nettype wire

### src/lbvs_tables.sv
`default_nettype none
// ============================================================================
// lbvs_tables
// Pose and inverse-bind matrix stores, one bank per influence, row per bone.
// ============================================================================
module lbvs_tables import lbvs_pkg::*;
(
    input  wire logic                             clk,
    input  wire logic                             adv,
    input  wire tbl_wr_t                          wr,
    input  wire logic [NUM_INFL-1:0][BONE_AW-1:0] rd_addr,
    output mat_t      [NUM_INFL-1:0]              pose_rows,
    output mat_t      [NUM_INFL-1:0]              inv_rows
);

    // Every bank holds the same contents so each influence has its own read port
    for (genvar b = 0; b < NUM_INFL; b++) begin : g_bank
        mat_t pose_mem [MAX_BONES];
        mat_t inv_mem  [MAX_BONES];
        mat_t pose_q_reg;
        mat_t inv_q_reg;

        always_ff @(posedge clk)
        begin
            if (wr.pose_we)
                pose_mem[wr.row][wr.elem] <= wr.value;
            if (wr.inv_we)
                inv_mem[wr.row][wr.elem] <= wr.value;
            if (adv)
            begin
                pose_q_reg <= pose_mem[rd_addr[b]];
                inv_q_reg  <= inv_mem[rd_addr[b]];
            end
        end

        assign pose_rows[b] = pose_q_reg;
        assign inv_rows[b]  = inv_q_reg;
    end

endmodule
`default_nettype wire

### src/lbvs_blend.sv
`default_nettype none
// ============================================================================
// lbvs_blend
// Per-bone pose times inverse bind, weight scaling and blend into one matrix.
// ============================================================================
module lbvs_blend import lbvs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire side_t                side_in,
    input  wire mat_t [NUM_INFL-1:0]  pose_rows,
    input  wire mat_t [NUM_INFL-1:0]  inv_rows,
    output logic                      skin_valid,
    output mat_t                      skin,
    output vec3_t                     pos,
    output vec3_t                     norm
);

    logic signed [63:0] prod_reg  [NUM_INFL][4][4][4];
    fix_t               pmat_next [NUM_INFL][MAT_ELEMS];
    fix_t               pmat_reg  [NUM_INFL][MAT_ELEMS];
    logic signed [48:0] wprod_reg [NUM_INFL][MAT_ELEMS];
    mat_t               skin_next;
    mat_t               skin_reg;
    side_t              side_reg  [4];
    logic [3:0]         valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    // Element products of pose row by inverse-bind column
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NUM_INFL; k++)
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        for (int m = 0; m < 4; m++)
                            prod_reg[k][r][c][m] <= $signed(pose_rows[k][r*4+m])
                                                  * $signed(inv_rows[k][m*4+c]);
            side_reg[0] <= side_in;
            for (int s = 1; s < 4; s++)
                side_reg[s] <= side_reg[s-1];
        end
    end

    // Round, sum, clamp; drop bones out of range
    always_comb
    begin
        logic signed [63:0] acc;
        acc = '0;
        for (int k = 0; k < NUM_INFL; k++)
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                begin
                    acc = '0;
                    for (int m = 0; m < 4; m++)
                        acc = acc + round_shr(prod_reg[k][r][c][m], FRAC_BITS);
                    pmat_next[k][r*4+c] = side_reg[0].bone_ok[k] ? sat32(acc) : '0;
                end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pmat_reg <= pmat_next;
            for (int k = 0; k < NUM_INFL; k++)
                for (int e = 0; e < MAT_ELEMS; e++)
                    wprod_reg[k][e] <= $signed(pmat_reg[k][e])
                                     * $signed({1'b0, side_reg[1].weights[k]});
        end
    end

    always_comb
    begin
        logic signed [63:0] acc;
        acc = '0;
        for (int e = 0; e < MAT_ELEMS; e++)
        begin
            acc = '0;
            for (int k = 0; k < NUM_INFL; k++)
                acc = acc + round_shr(64'(wprod_reg[k][e]), WEIGHT_FRAC);
            skin_next[e] = sat32(acc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            skin_reg <= skin_next;
    end

    assign skin_valid = valid_reg[3];
    assign skin       = skin_reg;
    assign pos        = side_reg[3].pos;
    assign norm       = side_reg[3].norm;

endmodule
`default_nettype wire

### src/lbvs_xform.sv
`default_nettype none
// ============================================================================
// lbvs_xform
// Position and normal transform by the blended matrix, divide preparation.
// ============================================================================
module lbvs_xform import lbvs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  adv,
    input  wire logic  skin_valid,
    input  wire mat_t  skin,
    input  wire vec3_t pos,
    input  wire vec3_t norm,
    output logic       div_valid,
    output div_in_t    div_in
);

    logic signed [63:0] tprod_reg [4][3];
    logic signed [63:0] nprod_reg [3][3];
    fix_t               tcol_reg  [4];
    fix_t               t_next    [4];
    fix_t               n_next    [3];
    fix_t               t_reg     [4];
    fix_t               n_reg     [3];
    div_in_t            div_next;
    div_in_t            div_reg;
    logic [2:0]         valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[1:0], skin_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
            begin
                tcol_reg[r] <= $signed(skin[r*4+3]);
                for (int c = 0; c < 3; c++)
                    tprod_reg[r][c] <= $signed(skin[r*4+c]) * $signed(pos[c]);
            end
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    nprod_reg[r][c] <= $signed(skin[r*4+c]) * $signed(norm[c]);
        end
    end

    // w column enters with a unit coordinate, so it adds unscaled
    always_comb
    begin
        logic signed [63:0] acc;
        acc = '0;
        for (int r = 0; r < 4; r++)
        begin
            acc = 64'(tcol_reg[r]);
            for (int c = 0; c < 3; c++)
                acc = acc + round_shr(tprod_reg[r][c], FRAC_BITS);
            t_next[r] = sat32(acc);
        end
        for (int r = 0; r < 3; r++)
        begin
            acc = '0;
            for (int c = 0; c < 3; c++)
                acc = acc + round_shr(nprod_reg[r][c], FRAC_BITS);
            n_next[r] = sat32(acc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg <= t_next;
            n_reg <= n_next;
        end
    end

    // Split into magnitudes and signs for the unsigned divider
    always_comb
    begin
        logic [31:0] mag;
        mag = '0;
        for (int r = 0; r < 3; r++)
        begin
            mag = t_reg[r][31] ? (~t_reg[r] + 32'd1) : t_reg[r];
            div_next.num[r]  = {mag, {FRAC_BITS{1'b0}}};
            div_next.neg[r]  = t_reg[r][31] ^ t_reg[3][31];
            div_next.norm[r] = n_reg[r];
        end
        div_next.den   = t_reg[3][31] ? (~t_reg[3] + 32'd1) : t_reg[3];
        div_next.fault = (t_reg[3] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            div_reg <= div_next;
    end

    assign div_valid = valid_reg[2];
    assign div_in    = div_reg;

endmodule
`default_nettype wire

### src/lbvs_divider.sv
`default_nettype none
// ============================================================================
// lbvs_divider
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// ============================================================================
module lbvs_divider import lbvs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    adv,
    input  wire logic    in_valid,
    input  wire div_in_t din,
    output logic         res_valid,
    output vec3_t        quot,
    output logic         fault,
    output vec3_t        norm
);

    localparam logic [QUOT_W-1:0] Q_NEG_LIM = QUOT_W'(64'h80000000);
    localparam logic [QUOT_W-1:0] Q_POS_LIM = QUOT_W'(64'h7fffffff);

    div_in_t                carry_reg [1:QUOT_W];
    logic [2:0][31:0]       rem_reg   [1:QUOT_W];
    logic [2:0][QUOT_W-1:0] q_reg     [1:QUOT_W];
    logic [QUOT_W:1]        valid_reg;

    for (genvar j = 0; j < QUOT_W; j++) begin : g_stage
        div_in_t                c_prev;
        logic [2:0][31:0]       rem_prev;
        logic [2:0][QUOT_W-1:0] q_prev;
        logic                   v_prev;
        div_in_t                c_next;
        logic [2:0][31:0]       rem_next;
        logic [2:0][QUOT_W-1:0] q_next;

        if (j == 0) begin : g_first
            assign c_prev   = din;
            assign rem_prev = '0;
            assign q_prev   = '0;
            assign v_prev   = in_valid;
        end else begin : g_rest
            assign c_prev   = carry_reg[j];
            assign rem_prev = rem_reg[j];
            assign q_prev   = q_reg[j];
            assign v_prev   = valid_reg[j];
        end

        always_comb
        begin
            logic [32:0] trial;
            trial  = '0;
            c_next = c_prev;
            for (int l = 0; l < 3; l++)
            begin
                trial          = {rem_prev[l], c_prev.num[l][QUOT_W-1]};
                c_next.num[l]  = {c_prev.num[l][QUOT_W-2:0], 1'b0};
                if (trial >= {1'b0, c_prev.den})
                begin
                    rem_next[l] = 32'(trial - {1'b0, c_prev.den});
                    q_next[l]   = {q_prev[l][QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = trial[31:0];
                    q_next[l]   = {q_prev[l][QUOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j+1] <= 1'b0;
            else if (adv)
                valid_reg[j+1] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                carry_reg[j+1] <= c_next;
                rem_reg[j+1]   <= rem_next;
                q_reg[j+1]     <= q_next;
            end
        end
    end

    // Apply sign and clamp; zero w forces zero positions
    always_comb
    begin
        logic [QUOT_W-1:0] q;
        q = '0;
        for (int l = 0; l < 3; l++)
        begin
            q = q_reg[QUOT_W][l];
            if (carry_reg[QUOT_W].fault)
                quot[l] = '0;
            else if (carry_reg[QUOT_W].neg[l])
                quot[l] = (q > Q_NEG_LIM) ? 32'h80000000 : 32'(-q);
            else
                quot[l] = (q > Q_POS_LIM) ? 32'h7fffffff : q[31:0];
        end
    end

    assign res_valid = valid_reg[QUOT_W];
    assign fault     = carry_reg[QUOT_W].fault;
    assign norm      = carry_reg[QUOT_W].norm;

endmodule
`default_nettype wire
